[rtl/interval_timeline_sequencer_core_macros.svh]
// Assertion helpers for the checker file.
`ifndef INTERVAL_TIMELINE_SEQUENCER_CORE_MACROS_SVH
`define INTERVAL_TIMELINE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itcs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itcs: next-cycle check failed");

`endif

[rtl/itcs_pkg.sv]
`timescale 1ns / 1ps
package itcs_pkg;

	localparam int POS_W       = 32;
	localparam int SCALE_W     = 16;
	localparam int SCALE_SHIFT = 8;
	localparam int PROD_W      = POS_W + SCALE_W + 1;
	localparam int OP_W        = 3;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 5;
	localparam int KIND_W      = 2;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = KIND_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = SCALE_W;

	localparam int DEF_ENTRIES     = 16;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_TIME  = 3'd1;
	localparam logic [OP_W-1:0] OP_START     = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
	localparam logic [OP_W-1:0] OP_WR_START  = 3'd4;
	localparam logic [OP_W-1:0] OP_WR_END    = 3'd5;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSED      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd2;

	localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [SCALE_W-1:0] time_scale;
		logic               paused;
		logic [CNT_W-1:0]   entry_count;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic signed [POS_W-1:0] value;
		logic [IDX_W-1:0]        idx;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_EV2,
		ST_WR_RD,
		ST_WR_EV,
		ST_DONE
	} back_state_t;

	function automatic logic in_window(input logic signed [POS_W-1:0] t,
			input logic signed [POS_W-1:0] lo, input logic signed [POS_W-1:0] hi);
		return (t >= lo) && (t < hi);
	endfunction

endpackage

[rtl/itcs_ram.sv]
`timescale 1ns / 1ps
module itcs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/itcs_front.sv]
`timescale 1ns / 1ps
module itcs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  itcs_pkg::cfg_t                 cfg,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [31:0] value, [35:32] index, [39:36] zero
	input  logic [itcs_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [2:0] opcode
	input  logic [itcs_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           push,
	output itcs_pkg::cmd_t                 push_data,
	input  logic                           full
);

	localparam int SH_W = itcs_pkg::PROD_W - itcs_pkg::SCALE_SHIFT;

	logic                                 accept;
	logic                                 s1_valid_q;
	logic [itcs_pkg::OP_W-1:0]            op_s1;
	logic signed [itcs_pkg::POS_W-1:0]    val_s1;
	logic [itcs_pkg::IDX_W-1:0]           idx_s1;
	logic signed [itcs_pkg::PROD_W-1:0]   prod_s1;
	logic [SH_W-1:0]                      scaled;
	logic                                 ovf;
	logic signed [itcs_pkg::POS_W-1:0]    delta;

	assign s_axis_tready = !s1_valid_q || !full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = s1_valid_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= s_axis_tuser;
			val_s1  <= s_axis_tdata[itcs_pkg::POS_W-1:0];
			idx_s1  <= s_axis_tdata[itcs_pkg::POS_W +: itcs_pkg::IDX_W];
			prod_s1 <= $signed(s_axis_tdata[itcs_pkg::POS_W-1:0])
				* $signed({1'b0, cfg.time_scale});
		end
	end

	// floor division by the scale unit, then clamp to the time range
	always_comb begin
		scaled = prod_s1[itcs_pkg::PROD_W-1:itcs_pkg::SCALE_SHIFT];
		ovf    = !((&scaled[SH_W-1:itcs_pkg::POS_W-1]) || !(|scaled[SH_W-1:itcs_pkg::POS_W-1]));
		if (ovf) begin
			delta = scaled[SH_W-1] ? itcs_pkg::POS_MIN : itcs_pkg::POS_MAX;
		end else begin
			delta = scaled[itcs_pkg::POS_W-1:0];
		end
	end

	always_comb begin
		push_data.op    = op_s1;
		push_data.value = (op_s1 == itcs_pkg::OP_TICK) ? delta : val_s1;
		push_data.idx   = idx_s1;
	end

endmodule

[rtl/itcs_fifo.sv]
`timescale 1ns / 1ps
module itcs_fifo #(
	parameter int DEPTH = itcs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  itcs_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output itcs_pkg::cmd_t pop_data,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	itcs_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/itcs_back.sv]
`timescale 1ns / 1ps
module itcs_back #(
	parameter int ENTRIES = itcs_pkg::DEF_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  itcs_pkg::cfg_t                 cfg,
	input  logic                           empty,
	input  itcs_pkg::cmd_t                 head,
	output logic                           pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] entry, [4] status, [7:5] zero
	output logic [itcs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [1:0] kind
	output logic [itcs_pkg::M_TUSER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast
);

	localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW    = itcs_pkg::POS_W;
	localparam int RAM_W = 2 * PW;

	typedef enum logic [1:0] {
		WALK_MOVE,
		WALK_TICK,
		WALK_STOP,
		WALK_START
	} walk_t;

	itcs_pkg::back_state_t state_q, state_d;

	logic signed [PW-1:0]            pos_q;
	logic                            running_q;
	logic                            then_start_q;
	logic [itcs_pkg::CNT_W-1:0]      i_q;
	logic [ENTRIES-1:0]              valid_q;
	logic                            valid_rd_q;
	itcs_pkg::cmd_t                  cmd_q;
	logic                            status_q;
	logic signed [PW-1:0]            old_q;
	logic signed [PW-1:0]            new_q;
	walk_t                           mode_q;

	logic                            m_valid_q;
	logic [itcs_pkg::KIND_W-1:0]     m_kind_q;
	logic [itcs_pkg::IDX_W-1:0]      m_entry_q;
	logic                            m_status_q;
	logic                            m_last_q;

	logic [itcs_pkg::CNT_W-1:0]      used;
	logic                            out_free;
	logic                            tick_go;
	logic                            set_go;
	logic                            bad_idx;
	logic                            walk_end;
	logic signed [PW:0]              tick_sum;
	logic signed [PW-1:0]            tick_pos;

	logic [RAM_W-1:0]                rd_data;
	logic signed [PW-1:0]            ws;
	logic signed [PW-1:0]            we;
	logic                            was;
	logic                            now;
	logic                            span;
	logic                            first_v;
	logic [itcs_pkg::KIND_W-1:0]     first_kind;
	logic                            two;

	logic signed [PW-1:0]            w_lo;
	logic signed [PW-1:0]            w_hi;
	logic                            w_was;
	logic                            w_now;
	logic                            w_need;

	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	logic                            wr_en;
	logic [AW-1:0]                   wr_addr;
	logic                            emit;
	logic [itcs_pkg::KIND_W-1:0]     e_kind;
	logic [itcs_pkg::IDX_W-1:0]      e_entry;
	logic                            e_status;
	logic                            e_last;

	itcs_ram #(
		.WIDTH(RAM_W),
		.DEPTH(ENTRIES)
	) u_win (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data({w_hi, w_lo}),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign used     = (int'(cfg.entry_count) > ENTRIES) ? itcs_pkg::CNT_W'(ENTRIES)
		: cfg.entry_count;
	assign out_free = !m_valid_q || m_axis_tready;
	assign tick_go  = running_q && !cfg.paused;
	assign set_go   = running_q && (head.value != pos_q);
	assign bad_idx  = {1'b0, head.idx} >= used;
	assign walk_end = (i_q >= used);
	assign wr_addr  = AW'(cmd_q.idx);

	always_comb begin
		tick_sum = {pos_q[PW-1], pos_q} + {head.value[PW-1], head.value};
		if (tick_sum[PW] != tick_sum[PW-1]) begin
			tick_pos = tick_sum[PW] ? itcs_pkg::POS_MIN : itcs_pkg::POS_MAX;
		end else begin
			tick_pos = tick_sum[PW-1:0];
		end
	end

	// entries never written read as an empty window at zero
	assign ws = valid_rd_q ? rd_data[PW-1:0] : '0;
	assign we = valid_rd_q ? rd_data[RAM_W-1:PW] : '0;

	always_comb begin
		was        = itcs_pkg::in_window(old_q, ws, we);
		now        = itcs_pkg::in_window(new_q, ws, we);
		span       = itcs_pkg::in_window(ws, old_q, new_q)
			&& itcs_pkg::in_window(we, old_q, new_q);
		first_v    = 1'b0;
		first_kind = itcs_pkg::KIND_STOP;
		two        = 1'b0;
		case (mode_q)
			WALK_MOVE, WALK_TICK: begin
				if (was && !now) begin
					first_v = 1'b1;
				end else if (!was && now) begin
					first_v    = 1'b1;
					first_kind = itcs_pkg::KIND_START;
				end else if ((mode_q == WALK_TICK) && span) begin
					first_v = 1'b1;
					two     = 1'b1;
				end
			end
			WALK_STOP: begin
				first_v = was;
			end
			WALK_START: begin
				first_v    = was;
				first_kind = itcs_pkg::KIND_START;
			end
			default: begin
				first_v = 1'b0;
			end
		endcase
	end

	always_comb begin
		w_lo   = (cmd_q.op == itcs_pkg::OP_WR_START) ? cmd_q.value : ws;
		w_hi   = (cmd_q.op == itcs_pkg::OP_WR_END) ? cmd_q.value : we;
		w_was  = itcs_pkg::in_window(pos_q, ws, we);
		w_now  = itcs_pkg::in_window(pos_q, w_lo, w_hi);
		w_need = running_q && (w_was != w_now);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			itcs_pkg::ST_IDLE: begin
				if (!empty) begin
					case (head.op)
						itcs_pkg::OP_TICK:     state_d = tick_go ? itcs_pkg::ST_RD
							: itcs_pkg::ST_DONE;
						itcs_pkg::OP_SET_TIME: state_d = set_go ? itcs_pkg::ST_RD
							: itcs_pkg::ST_DONE;
						itcs_pkg::OP_START:    state_d = itcs_pkg::ST_RD;
						itcs_pkg::OP_STOP:     state_d = running_q ? itcs_pkg::ST_RD
							: itcs_pkg::ST_DONE;
						itcs_pkg::OP_WR_START, itcs_pkg::OP_WR_END:
							state_d = bad_idx ? itcs_pkg::ST_DONE : itcs_pkg::ST_WR_RD;
						default:               state_d = itcs_pkg::ST_DONE;
					endcase
				end
			end
			itcs_pkg::ST_RD: begin
				if (!walk_end) begin
					state_d = itcs_pkg::ST_EV;
				end else if (!then_start_q) begin
					state_d = itcs_pkg::ST_DONE;
				end
			end
			itcs_pkg::ST_EV: begin
				if (!first_v) begin
					state_d = itcs_pkg::ST_RD;
				end else if (out_free) begin
					state_d = two ? itcs_pkg::ST_EV2 : itcs_pkg::ST_RD;
				end
			end
			itcs_pkg::ST_EV2: begin
				if (out_free) begin
					state_d = itcs_pkg::ST_RD;
				end
			end
			itcs_pkg::ST_WR_RD: begin
				state_d = itcs_pkg::ST_WR_EV;
			end
			itcs_pkg::ST_WR_EV: begin
				if (!w_need || out_free) begin
					state_d = itcs_pkg::ST_DONE;
				end
			end
			itcs_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = itcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = i_q[AW-1:0];
		wr_en    = 1'b0;
		emit     = 1'b0;
		e_kind   = first_kind;
		e_entry  = itcs_pkg::IDX_W'(i_q);
		e_status = 1'b0;
		e_last   = 1'b0;
		case (state_q)
			itcs_pkg::ST_IDLE: begin
				pop = !empty;
			end
			itcs_pkg::ST_RD: begin
				rd_en = !walk_end;
			end
			itcs_pkg::ST_EV: begin
				emit = first_v && out_free;
			end
			itcs_pkg::ST_EV2: begin
				emit   = out_free;
				e_kind = itcs_pkg::KIND_START;
			end
			itcs_pkg::ST_WR_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(cmd_q.idx);
			end
			itcs_pkg::ST_WR_EV: begin
				wr_en   = !w_need || out_free;
				emit    = w_need && out_free;
				e_kind  = w_was ? itcs_pkg::KIND_STOP : itcs_pkg::KIND_START;
				e_entry = cmd_q.idx;
			end
			itcs_pkg::ST_DONE: begin
				emit     = out_free;
				e_kind   = itcs_pkg::KIND_DONE;
				e_entry  = '0;
				e_status = status_q;
				e_last   = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= itcs_pkg::ST_IDLE;
			pos_q        <= '0;
			running_q    <= 1'b0;
			then_start_q <= 1'b0;
			i_q          <= '0;
			valid_q      <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				itcs_pkg::ST_IDLE: begin
					if (pop) begin
						i_q          <= '0;
						then_start_q <= (head.op == itcs_pkg::OP_START) && running_q;
						case (head.op)
							itcs_pkg::OP_TICK: begin
								if (tick_go) begin
									pos_q <= tick_pos;
								end
							end
							itcs_pkg::OP_SET_TIME: begin
								if (set_go) begin
									pos_q <= head.value;
								end
							end
							itcs_pkg::OP_START: begin
								pos_q     <= '0;
								running_q <= 1'b1;
							end
							itcs_pkg::OP_STOP: begin
								pos_q     <= '0;
								running_q <= 1'b0;
							end
							default: begin
								pos_q <= pos_q;
							end
						endcase
					end
				end
				itcs_pkg::ST_RD: begin
					if (walk_end && then_start_q) begin
						then_start_q <= 1'b0;
						i_q          <= '0;
					end
				end
				itcs_pkg::ST_EV: begin
					if (!first_v || (out_free && !two)) begin
						i_q <= itcs_pkg::CNT_W'(i_q + 1'b1);
					end
				end
				itcs_pkg::ST_EV2: begin
					if (out_free) begin
						i_q <= itcs_pkg::CNT_W'(i_q + 1'b1);
					end
				end
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			valid_rd_q <= valid_q[rd_addr];
		end
		if (emit) begin
			m_kind_q   <= e_kind;
			m_entry_q  <= e_entry;
			m_status_q <= e_status;
			m_last_q   <= e_last;
		end
		if (pop) begin
			cmd_q    <= head;
			status_q <= ((head.op == itcs_pkg::OP_WR_START)
				|| (head.op == itcs_pkg::OP_WR_END)) && bad_idx;
			old_q    <= ((head.op == itcs_pkg::OP_START) && !running_q) ? '0 : pos_q;
			new_q    <= (head.op == itcs_pkg::OP_SET_TIME) ? head.value : tick_pos;
			case (head.op)
				itcs_pkg::OP_TICK:     mode_q <= WALK_TICK;
				itcs_pkg::OP_SET_TIME: mode_q <= WALK_MOVE;
				itcs_pkg::OP_START:    mode_q <= running_q ? WALK_STOP : WALK_START;
				default:               mode_q <= WALK_STOP;
			endcase
		end else if ((state_q == itcs_pkg::ST_RD) && walk_end && then_start_q) begin
			mode_q <= WALK_START;
			old_q  <= '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {{(itcs_pkg::M_TDATA_W - itcs_pkg::IDX_W - 1){1'b0}},
		m_status_q, m_entry_q};

endmodule

[rtl/interval_timeline_sequencer_core.sv]
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata value,index  tuser opcode
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata entry,status tuser kind, tlast
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// A walk reads the window table once per entry in use and emits both events of a
// double event on a tick; a restart walks twice. A window write reads its entry and
// writes it back, and a command that walks nothing goes straight to its done beat.
// Reset clears position, running, the window valid bits, pause and entry count, and
// sets the time scale to 256; unwritten windows read as zero. Up to QUEUE_DEPTH + 1
// commands wait ahead; m_axis_tready low holds it.
module interval_timeline_sequencer_core #(
	parameter int ENTRIES     = itcs_pkg::DEF_ENTRIES,
	parameter int QUEUE_DEPTH = itcs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [31:0] value, [35:32] index, [39:36] zero
	input  logic [itcs_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [2:0] opcode
	input  logic [itcs_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] entry, [4] status, [7:5] zero
	output logic [itcs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [1:0] kind
	output logic [itcs_pkg::M_TUSER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [itcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [itcs_pkg::CFG_DAT_W-1:0] cfg_data
);

	itcs_pkg::cfg_t cfg_q;
	itcs_pkg::cmd_t push_data;
	itcs_pkg::cmd_t head;
	logic           push;
	logic           full;
	logic           pop;
	logic           empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_scale  <= itcs_pkg::SCALE_RESET;
			cfg_q.paused      <= 1'b0;
			cfg_q.entry_count <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				itcs_pkg::REG_TIME_SCALE:  cfg_q.time_scale  <= cfg_data;
				itcs_pkg::REG_PAUSED:      cfg_q.paused      <= cfg_data[0];
				itcs_pkg::REG_ENTRY_COUNT: cfg_q.entry_count <= cfg_data[itcs_pkg::CNT_W-1:0];
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	itcs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.push         (push),
		.push_data    (push_data),
		.full         (full)
	);

	itcs_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (head),
		.empty    (empty)
	);

	itcs_back #(
		.ENTRIES(ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

[rtl/itcs_checker.sv]
`timescale 1ns / 1ps
`include "interval_timeline_sequencer_core_macros.svh"
module itcs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [itcs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [itcs_pkg::M_TUSER_W-1:0] m_axis_tuser,
	input logic                           m_axis_tlast
);

	`ITCS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
	`ITCS_ASSERT_IMP(a_last_is_done, clk, arst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == itcs_pkg::KIND_DONE))
	`ITCS_ASSERT_IMP(a_done_entry_zero, clk, arst_n, m_axis_tvalid && (m_axis_tuser == itcs_pkg::KIND_DONE), m_axis_tdata[3:0] == 4'd0)
	`ITCS_ASSERT_IMP(a_event_clean, clk, arst_n, m_axis_tvalid && (m_axis_tuser != itcs_pkg::KIND_DONE), !m_axis_tdata[4] && ((m_axis_tuser == itcs_pkg::KIND_START) || (m_axis_tuser == itcs_pkg::KIND_STOP)))

endmodule

bind interval_timeline_sequencer_core itcs_checker u_itcs_checker (.*);
